/* rtl/core/gla_pkg.sv */
`timescale 1ns / 1ps

package gla_pkg;

  localparam int ADC_BITS          = 12;
  localparam int CFG_DATA_BITS     = 16;
  localparam int CFG_INDEX_BITS    = 3;
  localparam int PCT_BITS          = 7;
  localparam int MV_BITS           = 12;
  localparam int TICK_BITS_DEFAULT = 16;

  // Full scale of the converter is 2^ADC_BITS - 1.
  localparam int PCT_SCALE = 100;
  localparam int MV_SCALE  = 3300;

  localparam logic [15:0]         RESET_SAMPLE_INTERVAL = 16'd1000;
  localparam logic [ADC_BITS-1:0] RESET_ALARM_THRESHOLD = 12'd2000;
  localparam logic [ADC_BITS-1:0] RESET_WARN_THRESHOLD  = 12'd1450;
  localparam logic [15:0]         RESET_ALARM_ON_TICKS  = 16'd300;
  localparam logic [15:0]         RESET_ALARM_OFF_TICKS = 16'd200;
  localparam logic [15:0]         RESET_WARN_ON_TICKS   = 16'd100;
  localparam logic [15:0]         RESET_WARN_OFF_TICKS  = 16'd200;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SAMPLE_INTERVAL = 3'd0,
    REG_ALARM_THRESHOLD = 3'd1,
    REG_WARN_THRESHOLD  = 3'd2,
    REG_ALARM_ON_TICKS  = 3'd3,
    REG_ALARM_OFF_TICKS = 3'd4,
    REG_WARN_ON_TICKS   = 3'd5,
    REG_WARN_OFF_TICKS  = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    LEVEL_QUIET = 2'd0,
    LEVEL_WARN  = 2'd1,
    LEVEL_ALARM = 2'd2
  } level_t;

  typedef struct packed {
    logic [15:0]         sample_interval;
    logic [ADC_BITS-1:0] alarm_threshold;
    logic [ADC_BITS-1:0] warn_threshold;
    logic [15:0]         alarm_on_ticks;
    logic [15:0]         alarm_off_ticks;
    logic [15:0]         warn_on_ticks;
    logic [15:0]         warn_off_ticks;
  } cfg_t;

  typedef struct packed {
    logic                beeper;
    level_t              alert_level;
    logic                sample_taken;
    logic [ADC_BITS-1:0] held_reading;
    logic [PCT_BITS-1:0] level_percent;
    logic [MV_BITS-1:0]  millivolts;
  } result_t;

endpackage

/* rtl/core/gla_regs.sv */
`timescale 1ns / 1ps

module gla_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [gla_pkg::CFG_INDEX_BITS-1:0]  wr_index,
  input  logic [gla_pkg::CFG_DATA_BITS-1:0]   wr_data,
  output gla_pkg::cfg_t                       cfg
);
  import gla_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_interval <= RESET_SAMPLE_INTERVAL;
      cfg.alarm_threshold <= RESET_ALARM_THRESHOLD;
      cfg.warn_threshold  <= RESET_WARN_THRESHOLD;
      cfg.alarm_on_ticks  <= RESET_ALARM_ON_TICKS;
      cfg.alarm_off_ticks <= RESET_ALARM_OFF_TICKS;
      cfg.warn_on_ticks   <= RESET_WARN_ON_TICKS;
      cfg.warn_off_ticks  <= RESET_WARN_OFF_TICKS;
    end else if (wr_en) begin
      case (wr_index)
        REG_SAMPLE_INTERVAL: cfg.sample_interval <= wr_data[15:0];
        REG_ALARM_THRESHOLD: cfg.alarm_threshold <= wr_data[ADC_BITS-1:0];
        REG_WARN_THRESHOLD:  cfg.warn_threshold  <= wr_data[ADC_BITS-1:0];
        REG_ALARM_ON_TICKS:  cfg.alarm_on_ticks  <= wr_data[15:0];
        REG_ALARM_OFF_TICKS: cfg.alarm_off_ticks <= wr_data[15:0];
        REG_WARN_ON_TICKS:   cfg.warn_on_ticks   <= wr_data[15:0];
        REG_WARN_OFF_TICKS:  cfg.warn_off_ticks  <= wr_data[15:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

endmodule

/* rtl/core/gla_scale.sv */
`timescale 1ns / 1ps

module gla_scale (
  input  logic [gla_pkg::ADC_BITS-1:0] sample,
  output logic [gla_pkg::PCT_BITS-1:0] percent,
  output logic [gla_pkg::MV_BITS-1:0]  millivolts
);
  import gla_pkg::*;

  localparam int PCT_PROD_BITS = ADC_BITS + PCT_BITS;  // 4095*100 < 2^19
  localparam int MV_PROD_BITS  = ADC_BITS + MV_BITS;   // 4095*3300 < 2^24
  localparam int FULL_SCALE    = (1 << ADC_BITS) - 1;

  logic [PCT_PROD_BITS-1:0] pct_prod;
  logic [MV_PROD_BITS-1:0]  mv_prod;
  logic [PCT_BITS-1:0]      pct_q0;
  logic [MV_BITS-1:0]       mv_q0;
  logic [ADC_BITS:0]        pct_rem;
  logic [ADC_BITS:0]        mv_rem;

  // Divide by 2^n - 1: q0 = p >> n leaves remainder p[n-1:0] + q0, which stays
  // below twice the divisor, so one compare fixes the quotient.
  assign pct_prod = PCT_PROD_BITS'(sample) * PCT_PROD_BITS'(PCT_SCALE);
  assign mv_prod  = MV_PROD_BITS'(sample) * MV_PROD_BITS'(MV_SCALE);

  assign pct_q0 = pct_prod[PCT_PROD_BITS-1:ADC_BITS];
  assign mv_q0  = mv_prod[MV_PROD_BITS-1:ADC_BITS];

  assign pct_rem = {1'b0, pct_prod[ADC_BITS-1:0]} + (ADC_BITS+1)'(pct_q0);
  assign mv_rem  = {1'b0, mv_prod[ADC_BITS-1:0]} + (ADC_BITS+1)'(mv_q0);

  assign percent    = pct_q0 + PCT_BITS'(pct_rem >= (ADC_BITS+1)'(FULL_SCALE));
  assign millivolts = mv_q0 + MV_BITS'(mv_rem >= (ADC_BITS+1)'(FULL_SCALE));

endmodule

/* rtl/core/gla_state.sv */
`timescale 1ns / 1ps

module gla_state #(
  parameter int TICK_BITS = gla_pkg::TICK_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tick,
  input  logic [gla_pkg::ADC_BITS-1:0]  sample,
  input  logic [gla_pkg::PCT_BITS-1:0]  sample_percent,
  input  logic [gla_pkg::MV_BITS-1:0]   sample_mv,
  input  gla_pkg::cfg_t                 cfg,
  output gla_pkg::result_t              res
);
  import gla_pkg::*;

  localparam int CW = (TICK_BITS > 16) ? TICK_BITS : 16;

  logic [TICK_BITS-1:0] since_sample, since_sample_next;
  logic [TICK_BITS-1:0] alarm_elapsed, alarm_elapsed_next;
  logic [TICK_BITS-1:0] warn_elapsed, warn_elapsed_next;
  logic                 alarm_on, alarm_on_next;
  logic                 warn_on, warn_on_next;
  logic                 alarm_phase, alarm_phase_next;
  logic                 warn_phase, warn_phase_next;
  logic                 beeper_level, beeper_level_next;
  logic [ADC_BITS-1:0]  reading_hold, reading_hold_next;
  logic [PCT_BITS-1:0]  percent_hold, percent_hold_next;
  logic [MV_BITS-1:0]   millivolt_hold, millivolt_hold_next;

  logic [TICK_BITS-1:0] since_inc, alarm_inc, warn_inc;
  logic [15:0]          alarm_period, warn_period;
  logic                 take, alarm_hit, warn_hit;

  // Saturating tick counters
  assign since_inc = (&since_sample)  ? since_sample  : since_sample + 1'b1;
  assign alarm_inc = (&alarm_elapsed) ? alarm_elapsed : alarm_elapsed + 1'b1;
  assign warn_inc  = (&warn_elapsed)  ? warn_elapsed  : warn_elapsed + 1'b1;

  assign take = CW'(since_inc) >= CW'(cfg.sample_interval);

  assign alarm_period = alarm_phase ? cfg.alarm_on_ticks : cfg.alarm_off_ticks;
  assign warn_period  = warn_phase  ? cfg.warn_on_ticks  : cfg.warn_off_ticks;
  assign alarm_hit    = CW'(alarm_inc) >= CW'(alarm_period);
  assign warn_hit     = CW'(warn_inc)  >= CW'(warn_period);

  always_comb begin
    since_sample_next   = take ? '0 : since_inc;
    alarm_elapsed_next  = alarm_inc;
    warn_elapsed_next   = warn_inc;
    alarm_on_next       = alarm_on;
    warn_on_next        = warn_on;
    alarm_phase_next    = alarm_phase;
    warn_phase_next     = warn_phase;
    beeper_level_next   = beeper_level;
    reading_hold_next   = reading_hold;
    percent_hold_next   = percent_hold;
    millivolt_hold_next = millivolt_hold;

    if (take) begin
      reading_hold_next   = sample;
      percent_hold_next   = sample_percent;
      millivolt_hold_next = sample_mv;
      if (sample > cfg.alarm_threshold) begin
        alarm_on_next = 1'b1;
        warn_on_next  = 1'b0;
      end else if (sample > cfg.warn_threshold) begin
        alarm_on_next = 1'b0;
        warn_on_next  = 1'b1;
      end else begin
        alarm_on_next     = 1'b0;
        warn_on_next      = 1'b0;
        beeper_level_next = 1'b0;
      end
    end

    // Only the active pattern advances its phase; beeper keeps its level
    // across a pattern switch until the new pattern toggles.
    if (alarm_on_next) begin
      if (alarm_hit) begin
        alarm_phase_next   = !alarm_phase;
        alarm_elapsed_next = '0;
        beeper_level_next  = !alarm_phase;
      end
    end else if (warn_on_next) begin
      if (warn_hit) begin
        warn_phase_next   = !warn_phase;
        warn_elapsed_next = '0;
        beeper_level_next = !warn_phase;
      end
    end else begin
      beeper_level_next = 1'b0;
      alarm_phase_next  = 1'b0;
      warn_phase_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      since_sample   <= '0;
      alarm_elapsed  <= '0;
      warn_elapsed   <= '0;
      alarm_on       <= 1'b0;
      warn_on        <= 1'b0;
      alarm_phase    <= 1'b0;
      warn_phase     <= 1'b0;
      beeper_level   <= 1'b0;
      reading_hold   <= '0;
      percent_hold   <= '0;
      millivolt_hold <= '0;
    end else if (tick) begin
      since_sample   <= since_sample_next;
      alarm_elapsed  <= alarm_elapsed_next;
      warn_elapsed   <= warn_elapsed_next;
      alarm_on       <= alarm_on_next;
      warn_on        <= warn_on_next;
      alarm_phase    <= alarm_phase_next;
      warn_phase     <= warn_phase_next;
      beeper_level   <= beeper_level_next;
      reading_hold   <= reading_hold_next;
      percent_hold   <= percent_hold_next;
      millivolt_hold <= millivolt_hold_next;
    end
  end

  always_comb begin
    res.beeper        = beeper_level_next;
    res.alert_level   = alarm_on_next ? LEVEL_ALARM : (warn_on_next ? LEVEL_WARN : LEVEL_QUIET);
    res.sample_taken  = take;
    res.held_reading  = reading_hold_next;
    res.level_percent = percent_hold_next;
    res.millivolts    = millivolt_hold_next;
  end

endmodule

/* rtl/core/gas_level_alarm_beeper_core.sv */
`timescale 1ns / 1ps

// Gas level alarm beeper core.
// Input channel (in_valid/in_ready, adc_sample): one transaction per
// millisecond tick, carrying the current 12-bit converter reading.
// Output channel (out_valid/out_ready): one result per tick with the beeper
// drive, alert level, sample-taken flag and the held reading with its
// percent and millivolt scalings.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always
// ready; write registers only while no tick is in flight.
// The result of a tick is registered and is on the output in the cycle after the input
// transaction. Throughput: one tick per cycle while the receiver takes each result,
// set by the single output register that follows the tick logic.
// When the receiver stalls, the result holds in the output register and
// in_ready stays low until it is taken; a new tick is accepted in the same
// cycle the pending result leaves.
// Reset (rst, synchronous): all counters, phases and held values clear,
// the output empties and registers return to their default values.
module gas_level_alarm_beeper_core #(
  parameter int TICK_BITS = gla_pkg::TICK_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [gla_pkg::ADC_BITS-1:0]        adc_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                beeper,
  output logic [1:0]                          alert_level,
  output logic                                sample_taken,
  output logic [gla_pkg::ADC_BITS-1:0]        held_reading,
  output logic [gla_pkg::PCT_BITS-1:0]        level_percent,
  output logic [gla_pkg::MV_BITS-1:0]         millivolts,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gla_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [gla_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import gla_pkg::*;

  cfg_t                cfg;
  result_t             res;
  result_t             out_res;
  logic [PCT_BITS-1:0] sample_percent;
  logic [MV_BITS-1:0]  sample_mv;
  logic                in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  gla_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  gla_scale u_scale (
    .sample     (adc_sample),
    .percent    (sample_percent),
    .millivolts (sample_mv)
  );

  gla_state #(
    .TICK_BITS (TICK_BITS)
  ) u_state (
    .clk            (clk),
    .rst            (rst),
    .tick           (in_fire),
    .sample         (adc_sample),
    .sample_percent (sample_percent),
    .sample_mv      (sample_mv),
    .cfg            (cfg),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_res <= res;
    end
  end

  assign beeper        = out_res.beeper;
  assign alert_level   = out_res.alert_level;
  assign sample_taken  = out_res.sample_taken;
  assign held_reading  = out_res.held_reading;
  assign level_percent = out_res.level_percent;
  assign millivolts    = out_res.millivolts;

endmodule

/* rtl/core/gla_checker.sv */
`timescale 1ns / 1ps

module gla_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          beeper,
  input logic [1:0]                    alert_level,
  input logic                          sample_taken,
  input logic [gla_pkg::ADC_BITS-1:0]  held_reading,
  input logic [gla_pkg::PCT_BITS-1:0]  level_percent,
  input logic [gla_pkg::MV_BITS-1:0]   millivolts
);
  import gla_pkg::*;

  localparam logic [1:0]         QUIET_CODE = LEVEL_QUIET;
  localparam logic [PCT_BITS-1:0] PCT_MAX   = PCT_BITS'(PCT_SCALE);
  localparam logic [MV_BITS-1:0]  MV_MAX    = MV_BITS'(MV_SCALE);

  // Stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(beeper) && $stable(alert_level)
      && $stable(sample_taken) && $stable(held_reading) && $stable(level_percent)
      && $stable(millivolts))
    else $error("stalled result changed");

  // An empty output register never blocks the input.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // A quiet level never drives the beeper.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && alert_level == QUIET_CODE |-> !beeper)
    else $error("beeper on while quiet");

  // Scaled readings stay in range.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> level_percent <= PCT_MAX && millivolts <= MV_MAX)
    else $error("scaled reading out of range");

  // Reset empties the output.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind gas_level_alarm_beeper_core gla_checker u_gla_checker (.*);

/* test/gas_level_alarm_beeper_core_test.sv */
`timescale 1ns / 1ps

module gas_level_alarm_beeper_core_test;
  import gla_pkg::*;

  localparam int RUN_LIMIT     = 200000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_TICKS   = 57;
  localparam int HOLD_AT       = 150;
  localparam int HOLD_CYCLES   = 80;
  localparam int FULL_SCALE    = (1 << ADC_BITS) - 1;
  localparam logic [CFG_INDEX_BITS-1:0] NO_REG_INDEX = 3'd7;
  localparam logic [15:0] TICK_TOP = 16'hFFFF;

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      in_valid     = 1'b0;
  logic                      in_ready;
  logic [ADC_BITS-1:0]       adc_sample   = '0;
  logic                      out_valid;
  logic                      out_ready    = 1'b0;
  logic                      beeper;
  logic [1:0]                alert_level;
  logic                      sample_taken;
  logic [ADC_BITS-1:0]       held_reading;
  logic [PCT_BITS-1:0]       level_percent;
  logic [MV_BITS-1:0]        millivolts;
  logic                      cfg_valid    = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

  gas_level_alarm_beeper_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .adc_sample   (adc_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .beeper       (beeper),
    .alert_level  (alert_level),
    .sample_taken (sample_taken),
    .held_reading (held_reading),
    .level_percent(level_percent),
    .millivolts   (millivolts),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Beeper model state
  cfg_t                regs_now;
  logic [15:0]         since_cnt;
  logic [15:0]         alarm_cnt;
  logic [15:0]         warn_cnt;
  bit                  alarm_act;
  bit                  warn_act;
  bit                  alarm_ph;
  bit                  warn_ph;
  bit                  beep_lvl;
  logic [ADC_BITS-1:0] reading_q;
  logic [PCT_BITS-1:0] pct_q;
  logic [MV_BITS-1:0]  mv_q;

  result_t             expected_ticks[$];
  logic [ADC_BITS-1:0] pending_readings[$];

  int  ticks_queued   = 0;
  int  ticks_accepted = 0;
  int  results_seen   = 0;
  int  cycle_count    = 0;
  int  errors         = 0;
  bit  in_took        = 1'b0;
  int  burst_left     = 1;
  int  gap_left       = 0;
  int  hold_left      = 0;
  bit  hold_done      = 1'b0;
  int  seg_left       = 0;
  int  stall_pct      = 0;

  function automatic logic [15:0] count_up(logic [15:0] v);
    return (v == TICK_TOP) ? v : v + 16'd1;
  endfunction

  function automatic logic [ADC_BITS-1:0] clip_reading(int v);
    if (v < 0) return '0;
    if (v > FULL_SCALE) return ADC_BITS'(FULL_SCALE);
    return ADC_BITS'(v);
  endfunction

  function automatic cfg_t make_setting(logic [15:0] interval, logic [ADC_BITS-1:0] alarm_th,
                                        logic [ADC_BITS-1:0] warn_th, logic [15:0] a_on,
                                        logic [15:0] a_off, logic [15:0] w_on,
                                        logic [15:0] w_off);
    cfg_t c;
    c.sample_interval = interval;
    c.alarm_threshold = alarm_th;
    c.warn_threshold  = warn_th;
    c.alarm_on_ticks  = a_on;
    c.alarm_off_ticks = a_off;
    c.warn_on_ticks   = w_on;
    c.warn_off_ticks  = w_off;
    return c;
  endfunction

  function automatic logic [15:0] random_period();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 6));
  endfunction

  function automatic cfg_t random_setting(int phase);
    cfg_t c;
    int   w;
    w = $urandom_range(0, FULL_SCALE);
    c = make_setting(16'($urandom_range(0, 4)), clip_reading($urandom_range(w, FULL_SCALE)),
                     ADC_BITS'(w), random_period(), random_period(), random_period(),
                     random_period());
    if ($urandom_range(0, 4) == 0) c.alarm_threshold = ADC_BITS'($urandom);
    // extremes: periods that never expire, then an interval that never samples
    if (phase == 1) begin
      c = make_setting(16'd1, '0, '0, TICK_TOP, TICK_TOP, TICK_TOP, TICK_TOP);
    end else if (phase == 2) begin
      c.sample_interval = TICK_TOP;
    end
    return c;
  endfunction

  function automatic logic [ADC_BITS-1:0] pick_reading(int kind, cfg_t c);
    case (kind)
      1: return clip_reading(int'(c.alarm_threshold) + $urandom_range(0, 6) - 2);
      2: return clip_reading(int'(c.warn_threshold) + $urandom_range(0, 6) - 2);
      3: return ADC_BITS'($urandom_range(0, int'(c.warn_threshold)));
      4: return $urandom_range(0, 1) ? ADC_BITS'(FULL_SCALE) : '0;
      default: return ADC_BITS'($urandom);
    endcase
  endfunction

  task automatic run_beep_pattern(inout bit ph, inout logic [15:0] el,
                                  input logic [15:0] on_t, input logic [15:0] off_t);
    if (el >= (ph ? on_t : off_t)) begin
      ph       = !ph;
      el       = '0;
      beep_lvl = ph;
    end
  endtask

  task automatic predict_tick(input logic [ADC_BITS-1:0] s);
    result_t r;
    r.sample_taken = 1'b0;
    since_cnt = count_up(since_cnt);
    alarm_cnt = count_up(alarm_cnt);
    warn_cnt  = count_up(warn_cnt);
    if (since_cnt >= regs_now.sample_interval) begin
      since_cnt      = '0;
      r.sample_taken = 1'b1;
      reading_q      = s;
      pct_q          = PCT_BITS'(int'(s) * PCT_SCALE / FULL_SCALE);
      mv_q           = MV_BITS'(int'(s) * MV_SCALE / FULL_SCALE);
      if (s > regs_now.alarm_threshold) begin
        alarm_act = 1'b1;
        warn_act  = 1'b0;
      end else if (s > regs_now.warn_threshold) begin
        alarm_act = 1'b0;
        warn_act  = 1'b1;
      end else begin
        alarm_act = 1'b0;
        warn_act  = 1'b0;
        beep_lvl  = 1'b0;
      end
    end
    if (alarm_act) begin
      run_beep_pattern(alarm_ph, alarm_cnt, regs_now.alarm_on_ticks, regs_now.alarm_off_ticks);
    end else if (warn_act) begin
      run_beep_pattern(warn_ph, warn_cnt, regs_now.warn_on_ticks, regs_now.warn_off_ticks);
    end else begin
      beep_lvl = 1'b0;
      alarm_ph = 1'b0;
      warn_ph  = 1'b0;
    end
    r.beeper        = beep_lvl;
    r.alert_level   = alarm_act ? LEVEL_ALARM : (warn_act ? LEVEL_WARN : LEVEL_QUIET);
    r.held_reading  = reading_q;
    r.level_percent = pct_q;
    r.millivolts    = mv_q;
    expected_ticks.push_back(r);
  endtask

  task automatic apply_reg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                 input logic [CFG_DATA_BITS-1:0] d);
    case (idx)
      REG_SAMPLE_INTERVAL: regs_now.sample_interval = d;
      REG_ALARM_THRESHOLD: regs_now.alarm_threshold = d[ADC_BITS-1:0];
      REG_WARN_THRESHOLD:  regs_now.warn_threshold  = d[ADC_BITS-1:0];
      REG_ALARM_ON_TICKS:  regs_now.alarm_on_ticks  = d;
      REG_ALARM_OFF_TICKS: regs_now.alarm_off_ticks = d;
      REG_WARN_ON_TICKS:   regs_now.warn_on_ticks   = d;
      REG_WARN_OFF_TICKS:  regs_now.warn_off_ticks  = d;
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch_edges
    result_t want;
    in_took = 1'b0;
    if (!rst) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
        $display("[gas_level_alarm_beeper_core] ERROR");
        $finish;
      end else begin
        if (out_valid && out_ready) begin
          results_seen++;
          if (expected_ticks.size() == 0) begin
            errors++;
            $display("%0t: result with no tick pending, expected none, got beeper %0d level %0d",
                     $time, beeper, alert_level);
          end else begin
            want = expected_ticks.pop_front();
            check_field("beeper", want.beeper, beeper);
            check_field("alert_level", int'(want.alert_level), alert_level);
            check_field("sample_taken", want.sample_taken, sample_taken);
            check_field("held_reading", want.held_reading, held_reading);
            check_field("level_percent", want.level_percent, level_percent);
            check_field("millivolts", want.millivolts, millivolts);
          end
        end
        if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
        if (in_valid && in_ready) begin
          in_took = 1'b1;
          ticks_accepted++;
          predict_tick(adc_sample);
        end
      end
    end
  end

  // Tick sender: bursts of random length, random gaps between them
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_readings.size() > 0) begin
        in_valid   <= 1'b1;
        adc_sample <= pending_readings.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: stall rate changes per segment, one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT && pending_readings.size() > 20) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left  = $urandom_range(10, 60);
        stall_pct = $urandom_range(0, 3) * 28;
      end else begin
        seg_left--;
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic queue_tick(input logic [ADC_BITS-1:0] s);
    pending_readings.push_back(s);
    ticks_queued++;
  endtask

  task automatic wait_drained();
    while (ticks_accepted != ticks_queued || expected_ticks.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Thresholds go out with junk in the upper bits; the block must drop them
  task automatic load_setting(input cfg_t c);
    write_reg(REG_SAMPLE_INTERVAL, c.sample_interval);
    write_reg(REG_ALARM_THRESHOLD, {4'($urandom), c.alarm_threshold});
    write_reg(REG_WARN_THRESHOLD, {4'($urandom), c.warn_threshold});
    write_reg(REG_ALARM_ON_TICKS, c.alarm_on_ticks);
    write_reg(REG_ALARM_OFF_TICKS, c.alarm_off_ticks);
    write_reg(REG_WARN_ON_TICKS, c.warn_on_ticks);
    write_reg(REG_WARN_OFF_TICKS, c.warn_off_ticks);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_level_runs(input cfg_t c, input int count);
    int n;
    int kind;
    int len;
    n = 0;
    while (n < count) begin
      kind = $urandom_range(0, 4);
      len  = $urandom_range(1, 24);
      repeat (len) begin
        if (n < count) queue_tick(pick_reading(kind, c));
        n++;
      end
    end
  endtask

  initial begin
    cfg_t setting;
    logic [ADC_BITS-1:0] first_readings[$];
    logic [ADC_BITS-1:0] edge_readings[$];

    regs_now = make_setting(RESET_SAMPLE_INTERVAL, RESET_ALARM_THRESHOLD, RESET_WARN_THRESHOLD,
                            RESET_ALARM_ON_TICKS, RESET_ALARM_OFF_TICKS, RESET_WARN_ON_TICKS,
                            RESET_WARN_OFF_TICKS);
    since_cnt = '0;
    alarm_cnt = '0;
    warn_cnt  = '0;
    alarm_act = 1'b0;
    warn_act  = 1'b0;
    alarm_ph  = 1'b0;
    warn_ph   = 1'b0;
    beep_lvl  = 1'b0;
    reading_q = '0;
    pct_q     = '0;
    mv_q      = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // default registers: nothing sampled yet, all quiet
    repeat (6) queue_tick(ADC_BITS'($urandom));
    wait_drained();

    // threshold edges, pattern switches in both directions, full scale
    load_setting(make_setting(16'd1, 12'd2000, 12'd1450, 16'd2, 16'd1, 16'd1, 16'd2));
    first_readings = '{12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd2001, 12'd2000, 12'd1451,
                       12'd1451, 12'd1450, 12'd2001, 12'd1451, 12'd4095, 12'hAAA, 12'h555};
    foreach (first_readings[i]) queue_tick(first_readings[i]);
    wait_drained();

    // zero interval and zero periods: sample on every tick, toggle on every tick while a pattern is active
    load_setting(make_setting(16'd0, 12'h123, 12'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    write_reg(NO_REG_INDEX, 16'hFFFF);
    @(negedge clk);
    cfg_valid <= 1'b0;
    edge_readings = '{12'd0, 12'd1, 12'h123, 12'h124, 12'd4095, 12'd1, 12'd0};
    foreach (edge_readings[i]) queue_tick(edge_readings[i]);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      setting = random_setting(p);
      load_setting(setting);
      queue_level_runs(setting, PHASE_TICKS);
      wait_drained();
    end

    if (errors == 0) begin
      $display("[gas_level_alarm_beeper_core] OK");
    end else begin
      $display("[gas_level_alarm_beeper_core] ERROR");
    end
    $finish;
  end

endmodule
